/* src/array_table_insert_delete_search_core_macros.svh */
// Assertion macros for the ordered table core and its port checker.
// No dependencies; the files that assert include it by name.
`ifndef ARRAY_TABLE_INSERT_DELETE_SEARCH_CORE_MACROS_SVH
`define ARRAY_TABLE_INSERT_DELETE_SEARCH_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define ATIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ATIDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* src/atids_pkg.sv */
// Shared types and codes for the ordered table core.
// No dependencies.
package atids_pkg;

  localparam int IN_CMD_W  = 3;
  localparam int IN_POS_W  = 9;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int OUT_CNT_W = 9;

  // command codes
  localparam logic [IN_CMD_W-1:0] CMD_INS_AT    = 3'd0;
  localparam logic [IN_CMD_W-1:0] CMD_INS_FRONT = 3'd1;
  localparam logic [IN_CMD_W-1:0] CMD_INS_BACK  = 3'd2;
  localparam logic [IN_CMD_W-1:0] CMD_DEL_AT    = 3'd3;
  localparam logic [IN_CMD_W-1:0] CMD_DEL_FRONT = 3'd4;
  localparam logic [IN_CMD_W-1:0] CMD_DEL_BACK  = 3'd5;
  localparam logic [IN_CMD_W-1:0] CMD_SEARCH    = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [IN_CMD_W-1:0]     cmd;
    logic [IN_POS_W-1:0]     position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic                 found;
    logic                 appended_instead;
    logic [OUT_CNT_W-1:0] entries_now;
  } out_t;

endpackage

/* src/atids_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module atids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/atids_ctrl.sv */
// Command sequencer: decodes a transaction, walks the entry RAM one entry
// per cycle for shifts and searches, and keeps the entry count.
// Depends on atids_pkg.
module atids_ctrl #(
  parameter int TABLE_DEPTH = 256,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  atids_pkg::in_t              in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output atids_pkg::out_t             res_data,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [atids_pkg::VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [atids_pkg::VAL_W-1:0] mem_rdata
);
  import atids_pkg::*;

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > IN_POS_W) ? CW : IN_POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_DN   = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             pend, pend_next;
  logic [CW-1:0]    left, left_next;
  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    pend_addr, pend_addr_next;
  logic [AW-1:0]    tgt, tgt_next;
  logic [VAL_W-1:0] val, val_next;
  logic [ST_W-1:0]  res_status, res_status_next;
  logic             res_found, res_found_next;
  logic             res_app, res_app_next;

  logic [CW-1:0]    at_idx;
  logic             pos_ge;
  logic             full;

  assign pos_ge = CMPW'(in_data.position) >= CMPW'(count);
  assign full   = count == CW'(TABLE_DEPTH);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pend_next       = pend;
    left_next       = left;
    idx_next        = idx;
    pend_addr_next  = pend_addr;
    tgt_next        = tgt;
    val_next        = val;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_app_next    = res_app;
    at_idx          = '0;
    mem_we          = 1'b0;
    mem_waddr       = pend_addr;
    mem_wdata       = mem_rdata;
    mem_raddr       = idx;
    in_ready        = state == S_IDLE;
    res_valid       = state == S_DONE;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next        = in_data.value;
          res_status_next = ST_OK;
          res_found_next  = 1'b0;
          res_app_next    = 1'b0;
          pend_next       = 1'b0;
          state_next      = S_DONE;
          case (in_data.cmd)
            CMD_INS_AT, CMD_INS_FRONT, CMD_INS_BACK: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                if (in_data.cmd == CMD_INS_FRONT) begin
                  at_idx = '0;
                end else if (in_data.cmd == CMD_INS_BACK || pos_ge) begin
                  at_idx       = count;
                  res_app_next = in_data.cmd == CMD_INS_AT;
                end else begin
                  at_idx = CW'(in_data.position);
                end
                tgt_next   = AW'(at_idx);
                left_next  = count - at_idx;
                idx_next   = AW'(count - CW'(1));
                state_next = S_UP;
              end
            end
            CMD_DEL_AT, CMD_DEL_FRONT, CMD_DEL_BACK: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (in_data.cmd == CMD_DEL_AT && pos_ge) begin
                res_status_next = ST_RANGE;
              end else begin
                if (in_data.cmd == CMD_DEL_FRONT) begin
                  at_idx = '0;
                end else if (in_data.cmd == CMD_DEL_BACK) begin
                  at_idx = count - CW'(1);
                end else begin
                  at_idx = CW'(in_data.position);
                end
                left_next  = count - CW'(1) - at_idx;
                idx_next   = AW'(at_idx + CW'(1));
                state_next = S_DN;
              end
            end
            CMD_SEARCH: begin
              left_next  = count;
              idx_next   = '0;
              state_next = S_SRCH;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // move entries up one place, top first; read at idx, write at idx+1
      S_UP: begin
        mem_we = pend;
        if (left != '0) begin
          mem_raddr      = idx;
          pend_next      = 1'b1;
          pend_addr_next = idx + AW'(1);
          idx_next       = idx - AW'(1);
          left_next      = left - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we     = 1'b1;
            mem_waddr  = tgt;
            mem_wdata  = val;
            count_next = count + CW'(1);
            state_next = S_DONE;
          end
        end
      end

      // move entries down one place, bottom first; read at idx, write at idx-1
      S_DN: begin
        mem_we = pend;
        if (left != '0) begin
          mem_raddr      = idx;
          pend_next      = 1'b1;
          pend_addr_next = idx - AW'(1);
          idx_next       = idx + AW'(1);
          left_next      = left - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - CW'(1);
            state_next = S_DONE;
          end
        end
      end

      // linear scan; compare the entry read in the previous cycle
      S_SRCH: begin
        if (pend && mem_rdata == val) begin
          res_found_next = 1'b1;
          pend_next      = 1'b0;
          state_next     = S_DONE;
        end else if (left != '0) begin
          mem_raddr = idx;
          pend_next = 1'b1;
          idx_next  = idx + AW'(1);
          left_next = left - CW'(1);
        end else begin
          pend_next  = 1'b0;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    left       <= left_next;
    idx        <= idx_next;
    pend_addr  <= pend_addr_next;
    tgt        <= tgt_next;
    val        <= val_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_app    <= res_app_next;
  end

  always_comb begin
    res_data.status           = res_status;
    res_data.found            = res_found;
    res_data.appended_instead = res_app;
    res_data.entries_now      = OUT_CNT_W'(count);
  end

endmodule

/* src/atids_outreg.sv */
// One-entry output register between the sequencer and the result channel.
// Depends on atids_pkg.
module atids_outreg (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  output logic            res_ready,
  input  atids_pkg::out_t res_data,
  output logic            out_valid,
  input  logic            out_ready,
  output atids_pkg::out_t out_data
);
  import atids_pkg::*;

  logic load;

  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_data;
    end
  end

endmodule

/* src/array_table_insert_delete_search_core.sv */
// Ordered table core: one command per transaction, one result per command.
// Refused commands and code 7 finish without a RAM walk; a search reads entries
// until a match or the end; an insert opens a gap at its target and a delete
// closes one, each shifting the later entries one place.
// One command at a time, the next taken in the cycle after the result loads
// into the output register. Sync reset empties the table.
module array_table_insert_delete_search_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  atids_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output atids_pkg::out_t out_data
);
  import atids_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // entry RAM port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // sequencer to output register
  logic res_valid;
  logic res_ready;
  out_t res_data;

  // Sequencer. Inserts walk from the top entry down, deletes from the
  // target up, searches from entry 0; each shift step issues one read and writes
  // back the entry read the step before, so reads and writes never touch
  // the same entry in one cycle.
  atids_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Entry store; only entries below the count are ever read, so it needs
  // no clearing after reset.
  atids_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Result register; frees the sequencer while a result waits downstream.
  atids_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* src/atids_checker.sv */
// Port-level checker for the ordered table core, bound to the top level.
// Depends on atids_pkg and the core's macro header.
`include "array_table_insert_delete_search_core_macros.svh"

module atids_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input atids_pkg::out_t out_data
);
  import atids_pkg::*;

  `ATIDS_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid && in_ready, "not idle after reset")
  `ATIDS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped or changed while stalled")
  `ATIDS_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")
  `ATIDS_ASSERT(a_full, out_valid && out_data.status == ST_FULL |-> !out_data.found && !out_data.appended_instead && out_data.entries_now == OUT_CNT_W'(TABLE_DEPTH), "bad full-table result")
  `ATIDS_ASSERT(a_flags_ok, out_valid && (out_data.found || out_data.appended_instead) |-> out_data.status == ST_OK, "flag set on failed command")

endmodule

bind array_table_insert_delete_search_core atids_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_atids_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for array_table_insert_delete_search_core.
// Depends on atids_pkg and the core RTL; a mirror table in the bench predicts every result.
module testbench;
  import atids_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int LIMIT_CYCLES = 2_000_000;  // several times the slowest legal run
  localparam int DRAIN_CYCLES = 300;        // longest shift or scan plus margin
  localparam int MAX_SHOWN    = 10;
  // command code the core must treat as a no-op
  localparam logic [IN_CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // set for the tail of the run: no idling on either side
  bit calm = 1'b0;

  // mirror of the table contents and queue of results still owed by the core
  logic [VAL_W-1:0] mirror_entries [$];
  out_t             awaited_results [$];

  // tallies for the closing summary
  int unsigned n_commands, n_full, n_empty, n_range, n_appended, n_hits, peak_entries;
  int unsigned fail_count, checked_count;
  longint unsigned cycles = 0;

  array_table_insert_delete_search_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Applies one accepted command to the mirror and returns the result the core owes.
  function automatic out_t apply_to_mirror(in_t c);
    out_t        r;
    int unsigned n;
    r          = '0;
    r.status   = ST_OK;
    n          = mirror_entries.size();
    n_commands++;
    case (c.cmd)
      CMD_INS_AT, CMD_INS_FRONT, CMD_INS_BACK: begin
        if (n >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else if (c.cmd == CMD_INS_FRONT) begin
          mirror_entries.push_front(c.value);
        end else if (c.cmd == CMD_INS_BACK || c.position >= n) begin
          // insert_at at or past the end turns into an append and says so
          r.appended_instead = (c.cmd == CMD_INS_AT);
          if (c.cmd == CMD_INS_AT) n_appended++;
          mirror_entries.push_back(c.value);
        end else begin
          mirror_entries.insert(c.position, c.value);
        end
      end
      CMD_DEL_AT, CMD_DEL_FRONT, CMD_DEL_BACK: begin
        // empty check comes ahead of the range check
        if (n == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else if (c.cmd == CMD_DEL_FRONT) begin
          void'(mirror_entries.pop_front());
        end else if (c.cmd == CMD_DEL_BACK) begin
          void'(mirror_entries.pop_back());
        end else if (c.position >= n) begin
          r.status = ST_RANGE;
          n_range++;
        end else begin
          mirror_entries.delete(c.position);
        end
      end
      CMD_SEARCH: begin
        foreach (mirror_entries[i]) begin
          if (mirror_entries[i] == c.value) r.found = 1'b1;
        end
        if (r.found) n_hits++;
      end
      default: begin
      end
    endcase
    r.entries_now = OUT_CNT_W'(mirror_entries.size());
    if (mirror_entries.size() > peak_entries) peak_entries = mirror_entries.size();
    return r;
  endfunction

  function automatic in_t cmd_of(logic [IN_CMD_W-1:0] cmd, int unsigned pos,
                                 logic [VAL_W-1:0] val);
    in_t c;
    c.cmd      = cmd;
    c.position = IN_POS_W'(pos);
    c.value    = val;
    return c;
  endfunction

  // Extremes and a small pool (for duplicates and search hits) mixed into random values.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // One random command; grow_pct steers the split between inserts and deletes
  // so the entry count wanders across its whole range.
  function automatic in_t random_cmd(int unsigned grow_pct);
    in_t         c;
    int unsigned roll, n;
    n          = mirror_entries.size();
    roll       = $urandom_range(0, 99);
    c.value    = pick_value();
    c.position = IN_POS_W'($urandom_range(0, 511));
    if (roll < 15) begin
      c.cmd = CMD_SEARCH;
      if (n != 0 && $urandom_range(0, 1) == 1) c.value = mirror_entries[$urandom_range(0, n - 1)];
    end else if (roll < 17) begin
      c.cmd = CMD_UNUSED;
    end else if (roll < 17 + grow_pct * 83 / 100) begin
      case ($urandom_range(0, 3))
        0:       c.cmd = CMD_INS_FRONT;
        1:       c.cmd = CMD_INS_BACK;
        default: c.cmd = CMD_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       c.cmd = CMD_DEL_FRONT;
        1:       c.cmd = CMD_DEL_BACK;
        default: c.cmd = CMD_DEL_AT;
      endcase
    end
    // most positions land on a live entry or just past the end
    if ($urandom_range(0, 3) != 0) c.position = IN_POS_W'($urandom_range(0, n));
    return c;
  endfunction

  // Sends one transaction: optional idle burst, then valid held until accepted.
  // in_ready is read right after the edge, i.e. the value that decided acceptance.
  task automatic issue_command(in_t c);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(apply_to_mirror(c));
  endtask

  // Result side: stalls in random bursts between runs of readiness, none once calm is set.
  initial begin : sink_pacing
    int unsigned stall;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        stall = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Every result transaction is matched against the oldest owed result.
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("[%0t] result with nothing outstanding: status=%0d found=%0d app=%0d cnt=%0d",
                   $time, out_data.status, out_data.found, out_data.appended_instead,
                   out_data.entries_now);
      end else begin
        want = awaited_results.pop_front();
        checked_count++;
        if (out_data.status !== want.status || out_data.found !== want.found ||
            out_data.appended_instead !== want.appended_instead ||
            out_data.entries_now !== want.entries_now) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("[%0t] result %0d: want st=%0d fnd=%0d app=%0d cnt=%0d, got st=%0d fnd=%0d app=%0d cnt=%0d",
                     $time, checked_count, want.status, want.found, want.appended_instead,
                     want.entries_now, out_data.status, out_data.found,
                     out_data.appended_instead, out_data.entries_now);
        end
      end
    end
  end

  // Corner cases on a small table: empty deletes, search on empty, the unused
  // code, field extremes, insert_at past the end and exactly at the end,
  // out-of-range deletes, then a drain back to empty.
  task automatic test_corner_cases();
    issue_command(cmd_of(CMD_DEL_AT, 0, 0));
    issue_command(cmd_of(CMD_DEL_FRONT, 0, 0));
    issue_command(cmd_of(CMD_DEL_BACK, 511, 32'hFFFF_FFFF));
    issue_command(cmd_of(CMD_SEARCH, 0, 0));
    issue_command(cmd_of(CMD_UNUSED, 511, 32'hFFFF_FFFF));
    issue_command(cmd_of(CMD_INS_AT, 511, 32'h8000_0000));
    issue_command(cmd_of(CMD_INS_FRONT, 0, 32'h7FFF_FFFF));
    issue_command(cmd_of(CMD_INS_BACK, 0, 0));
    issue_command(cmd_of(CMD_INS_AT, 1, 32'hFFFF_FFFF));
    issue_command(cmd_of(CMD_INS_AT, 0, 1));
    issue_command(cmd_of(CMD_INS_AT, 5, 2));
    issue_command(cmd_of(CMD_SEARCH, 0, 32'h8000_0000));
    issue_command(cmd_of(CMD_SEARCH, 511, 32'h7FFF_FFFF));
    issue_command(cmd_of(CMD_SEARCH, 0, 32'h1234_5678));
    issue_command(cmd_of(CMD_DEL_AT, 6, 0));
    issue_command(cmd_of(CMD_DEL_AT, 511, 0));
    issue_command(cmd_of(CMD_DEL_AT, 2, 0));
    issue_command(cmd_of(CMD_DEL_FRONT, 0, 0));
    issue_command(cmd_of(CMD_DEL_BACK, 0, 0));
    issue_command(cmd_of(CMD_SEARCH, 0, 32'hFFFF_FFFF));
    issue_command(cmd_of(CMD_UNUSED, 0, 0));
    while (mirror_entries.size() != 0) issue_command(cmd_of(CMD_DEL_AT, 0, 0));
    issue_command(cmd_of(CMD_SEARCH, 0, 0));
  endtask

  // Fill to the depth with random inserts, hit every insert on a full table,
  // step off and back onto the limit, then drain to empty.
  task automatic test_fill_and_drain();
    while (mirror_entries.size() < TABLE_DEPTH) issue_command(random_cmd(100));
    issue_command(cmd_of(CMD_INS_AT, 0, 32'h8000_0000));
    issue_command(cmd_of(CMD_INS_AT, 511, 32'h7FFF_FFFF));
    issue_command(cmd_of(CMD_INS_FRONT, 0, 0));
    issue_command(cmd_of(CMD_INS_BACK, 0, 32'hFFFF_FFFF));
    issue_command(cmd_of(CMD_SEARCH, 0, mirror_entries[TABLE_DEPTH - 1]));
    issue_command(cmd_of(CMD_DEL_AT, TABLE_DEPTH, 0));
    issue_command(cmd_of(CMD_DEL_AT, TABLE_DEPTH - 1, 0));
    issue_command(cmd_of(CMD_INS_AT, 0, $urandom()));
    issue_command(cmd_of(CMD_INS_BACK, 0, $urandom()));
    while (mirror_entries.size() != 0) issue_command(random_cmd(0));
    issue_command(cmd_of(CMD_DEL_BACK, 0, 0));
  endtask

  // Alternating growth and shrink phases with random idling on both sides.
  task automatic test_random_mix();
    for (int phase = 0; phase < 5; phase++) begin
      repeat (140) issue_command(random_cmd((phase % 2 == 0) ? 80 : 25));
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (150) issue_command(random_cmd(50));
  endtask

  initial begin : run_tests
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_fill_and_drain();
    test_random_mix();
    test_steady_stream();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // anything arriving now is an extra result and gets flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands (%0d results checked), peak %0d entries, %0d search hits.",
             n_commands, checked_count, peak_entries, n_hits);
    $display("Refusals: %0d full, %0d empty, %0d out of range; %0d appends past end; %0d cycles.",
             n_full, n_empty, n_range, n_appended, cycles);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
